// ===== hw/rtl/fifo_priority_extract_queue_core_assert.svh =====
// Assertion macros for the checker file of this block.
`ifndef FIFO_PRIORITY_EXTRACT_QUEUE_CORE_ASSERT_SVH
`define FIFO_PRIORITY_EXTRACT_QUEUE_CORE_ASSERT_SVH

// Checked only outside reset.
`define FPEQ_CHECK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define FPEQ_CHECK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fpeq_pkg.sv =====
package fpeq_pkg;

  localparam int DEPTH     = 16;
  localparam int ID_BITS   = 16;
  localparam int PRIO_BITS = 8;

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = ID_BITS + PRIO_BITS;

  // Field widths of the channels
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int IDF_W    = 16;
  localparam int PRIOF_W  = 8;
  localparam int COUNT_W  = 5;

  localparam logic [FUNC_W-1:0] FUNC_PUSH    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXTRACT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [IDF_W-1:0]   entry_id;
    logic [PRIOF_W-1:0] entry_priority;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDF_W-1:0]    out_id;
    logic [PRIOF_W-1:0]  out_priority;
    logic [COUNT_W-1:0]  count;
  } rsp_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  // Store port controls from the sequencer
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

endpackage

// ===== hw/rtl/fpeq_ram.sv =====
module fpeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fpeq_ctrl.sv =====
module fpeq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  fpeq_pkg::req_t              req,
  output logic                        res_valid,
  input  logic                        res_ready,
  output fpeq_pkg::rsp_t              res,
  output fpeq_pkg::ram_req_t          ram,
  input  logic [fpeq_pkg::ENTRY_W-1:0] ram_rdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  localparam logic [fpeq_pkg::CNT_W-1:0] CNT_ONE  = fpeq_pkg::CNT_W'(1);
  localparam logic [fpeq_pkg::CNT_W-1:0] CNT_FULL = fpeq_pkg::CNT_W'(fpeq_pkg::DEPTH);

  logic [1:0]                       state;
  logic [fpeq_pkg::CNT_W-1:0]       held;
  logic [fpeq_pkg::CNT_W-1:0]       rd_idx;
  logic [fpeq_pkg::CNT_W-1:0]       cmp_idx;
  logic [fpeq_pkg::CNT_W-1:0]       scan_lim;
  logic [fpeq_pkg::CNT_W-1:0]       best_idx;
  logic [fpeq_pkg::CNT_W-1:0]       wr_idx;
  logic                             cmp_vld;
  logic                             sh_vld;
  logic [fpeq_pkg::ID_BITS-1:0]     best_id;
  logic [fpeq_pkg::PRIO_BITS-1:0]   best_prio;
  logic [fpeq_pkg::STATUS_W-1:0]    status;

  fpeq_pkg::entry_t                 rd_entry;
  logic                             take;
  logic [fpeq_pkg::CNT_W-1:0]       best_idx_next;
  logic                             rd_more;

  assign rd_entry  = fpeq_pkg::entry_t'(ram_rdata);
  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_FIN);

  // The one comparator: strictly greater keeps the oldest on a tie
  assign take          = cmp_vld && ((cmp_idx == '0) || (rd_entry.prio > best_prio));
  assign best_idx_next = take ? cmp_idx : best_idx;
  assign rd_more       = (state == S_SCAN) ? (rd_idx < scan_lim) : (rd_idx < held);

  always_comb begin
    ram       = '0;
    ram.raddr = rd_idx[fpeq_pkg::IDX_W-1:0];
    if (state == S_IDLE && req_valid && req.func == fpeq_pkg::FUNC_PUSH && held != CNT_FULL) begin
      ram.we    = 1'b1;
      ram.waddr = held[fpeq_pkg::IDX_W-1:0];
      ram.wdata = {fpeq_pkg::ID_BITS'(req.entry_id), fpeq_pkg::PRIO_BITS'(req.entry_priority)};
    end else if (state == S_SHIFT && sh_vld) begin
      ram.we    = 1'b1;
      ram.waddr = wr_idx[fpeq_pkg::IDX_W-1:0];
      ram.wdata = ram_rdata;
    end
  end

  always_comb begin
    res.status       = status;
    res.out_id       = fpeq_pkg::IDF_W'(best_id);
    res.out_priority = fpeq_pkg::PRIOF_W'(best_prio);
    res.count        = fpeq_pkg::COUNT_W'(held);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      held    <= '0;
      cmp_vld <= 1'b0;
      sh_vld  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            best_id   <= '0;
            best_prio <= '0;
            rd_idx    <= '0;
            cmp_vld   <= 1'b0;
            if (req.func == fpeq_pkg::FUNC_PUSH) begin
              state <= S_FIN;
              if (held == CNT_FULL) begin
                status <= fpeq_pkg::ST_FULL;
              end else begin
                status <= fpeq_pkg::ST_DONE;
                held   <= held + CNT_ONE;
              end
            end else if (req.func == fpeq_pkg::FUNC_POP ||
                         req.func == fpeq_pkg::FUNC_EXTRACT) begin
              if (held == '0) begin
                status <= fpeq_pkg::ST_EMPTY;
                state  <= S_FIN;
              end else begin
                status   <= fpeq_pkg::ST_DONE;
                scan_lim <= (req.func == fpeq_pkg::FUNC_POP) ? CNT_ONE : held;
                state    <= S_SCAN;
              end
            end else begin
              status <= fpeq_pkg::ST_DONE;
              state  <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          cmp_idx <= rd_idx;
          if (take) begin
            best_id   <= rd_entry.id;
            best_prio <= rd_entry.prio;
          end
          best_idx <= best_idx_next;
          if (cmp_vld && cmp_idx == scan_lim - CNT_ONE) begin
            // last compare seen: close the gap behind the winner
            rd_idx  <= best_idx_next + CNT_ONE;
            wr_idx  <= best_idx_next;
            cmp_vld <= 1'b0;
            sh_vld  <= 1'b0;
            state   <= S_SHIFT;
          end else begin
            cmp_vld <= rd_more;
            if (rd_more) begin
              rd_idx <= rd_idx + CNT_ONE;
            end
          end
        end
        S_SHIFT: begin
          sh_vld <= rd_more;
          if (rd_more) begin
            rd_idx <= rd_idx + CNT_ONE;
          end
          if (sh_vld) begin
            wr_idx <= wr_idx + CNT_ONE;
          end
          if (!rd_more && !sh_vld) begin
            held  <= held - CNT_ONE;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/fifo_priority_extract_queue_core.sv =====
// Push, refused, empty or unused-code operations go straight from accept to result; pop
// scans the oldest entry, extract all held entries, and both then close the gap.
// Flow: one item at a time, set by the single store read port shared by scan and compaction.
// Reset: synchronous, active high; queue empties, no result pending, store left as is.

// Structure
//   fpeq_ctrl : sequencer with one priority comparator. An extract walks the
//               entries oldest first, one store read a cycle, keeping the best.
//               It then closes the gap by copying each later entry down one
//               slot (read one cycle, write the next, overlapped).
//   fpeq_ram  : entry store, one write and one registered read port.
//   here      : result register, so a new item is taken while the previous
//               result still waits on rsp_ready.
// Only data from slots below the held count is ever used, so the store needs no clear.
module fifo_priority_extract_queue_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  fpeq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output fpeq_pkg::rsp_t rsp
);

  logic                         res_valid;
  logic                         res_ready;
  fpeq_pkg::rsp_t               res;
  fpeq_pkg::ram_req_t           ram;
  logic [fpeq_pkg::ENTRY_W-1:0] ram_rdata;

  // Result register frees as soon as the downstream side takes the item
  assign res_ready = !rsp_valid || rsp_ready;

  fpeq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram       (ram),
    .ram_rdata (ram_rdata)
  );

  fpeq_ram #(
    .WIDTH (fpeq_pkg::ENTRY_W),
    .DEPTH (fpeq_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  // Payload only moves when a new result is loaded
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

// ===== hw/rtl/fpeq_chk.sv =====
`include "fifo_priority_extract_queue_core_assert.svh"

module fpeq_chk (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input fpeq_pkg::rsp_t rsp
);

  localparam logic [fpeq_pkg::COUNT_W-1:0] FULL_COUNT = fpeq_pkg::COUNT_W'(fpeq_pkg::DEPTH);

  logic stalled;
  logic flagged;
  logic no_entry;
  logic is_full;
  logic at_full;

  assign stalled  = rsp_valid && !rsp_ready;
  assign flagged  = rsp_valid && (rsp.status != fpeq_pkg::ST_DONE);
  assign no_entry = (rsp.out_id == '0) && (rsp.out_priority == '0);
  assign is_full  = (rsp.status == fpeq_pkg::ST_FULL);
  assign at_full  = (rsp.count == FULL_COUNT);

  `FPEQ_CHECK(a_rsp_hold, clk, rst, stalled |=> rsp_valid && $stable(rsp), "stalled item changed")
  `FPEQ_CHECK_ALWAYS(a_rst_clear, clk, rst |=> !rsp_valid, "item after reset")
  `FPEQ_CHECK(a_count_max, clk, rst, rsp_valid |-> rsp.count <= FULL_COUNT, "count beyond depth")
  `FPEQ_CHECK(a_nothing_out, clk, rst, flagged |-> no_entry, "entry on refused operation")
  `FPEQ_CHECK(a_status_count, clk, rst, flagged |-> is_full == at_full, "status disagrees with count")

endmodule

bind fifo_priority_extract_queue_core fpeq_chk u_chk (.*);
